/* src/svd_pkg.sv */
package svd_pkg;

    // Coordinate format: signed fixed point with FRAC_BITS fractional bits.
    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 8;
    localparam int VOXEL_WIDTH = 16;
    localparam int RADIUS_WIDTH = COORD_WIDTH - 1;

    // Signed coordinate difference and its magnitude.
    localparam int DIFF_W = COORD_WIDTH + 1;
    // Outer bound radius + voxel_size; every root and every in-range magnitude fits here.
    localparam int OUT_W  = ((RADIUS_WIDTH > VOXEL_WIDTH) ? RADIUS_WIDTH : VOXEL_WIDTH) + 1;
    localparam int CMP_W  = (DIFF_W > OUT_W) ? DIFF_W : OUT_W;
    localparam int SQ_W   = 2 * OUT_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int RT_W   = OUT_W;
    localparam int TR_W   = SQ_W + 2;
    // Signed ramp difference and its product with 127.
    localparam int DD_W   = RT_W + 1;
    localparam int PR_W   = DD_W + 7;

    localparam int DENS_W = 8;

    // Stream and configuration port widths.
    localparam int IN_DATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((1 + DENS_W + 7) / 8) * 8;
    localparam int CFG_W      = (COORD_WIDTH > VOXEL_WIDTH) ? COORD_WIDTH : VOXEL_WIDTH;
    localparam int CFG_IDX_W  = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOXEL    = 3'd4;

    // Reset values in raw fixed-point units.
    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RST = RADIUS_WIDTH'(256);
    localparam logic [VOXEL_WIDTH-1:0]  VOXEL_RST  = VOXEL_WIDTH'(256);

    localparam int DENS_FULL = 127;

endpackage

/* src/sphere_voxel_density.sv */
// Pipeline: six front stages, one stage per root bit of the 24-step square root, two ramp
// stages, one output register. Throughput: one beat per cycle; the stages carry their own
// valid bits and close up bubbles, so an input beat is taken whenever any stage downstream
// can move. Reset (rst_n low, asynchronous) empties the pipeline and sets the centre to 0
// and the radius and voxel size to 256; centre writes affect beats accepted after the write
// edge, while radius and voxel writes also reach beats already in the pipeline.
module sphere_voxel_density
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pos_x, pos_y, pos_z from the lowest bit up
    input  logic [svd_pkg::IN_DATA_W-1:0]       s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // touched, density, zero fill from the lowest bit up
    output logic [svd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,

    input  logic                                cfg_we,
    input  logic [svd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [svd_pkg::CFG_W-1:0]           cfg_data
);

    localparam int CW     = svd_pkg::COORD_WIDTH;
    localparam int DIFF_W = svd_pkg::DIFF_W;
    localparam int OUT_W  = svd_pkg::OUT_W;
    localparam int CMP_W  = svd_pkg::CMP_W;
    localparam int SQ_W   = svd_pkg::SQ_W;
    localparam int SUM_W  = svd_pkg::SUM_W;
    localparam int RT_W   = svd_pkg::RT_W;
    localparam int TR_W   = svd_pkg::TR_W;
    localparam int DD_W   = svd_pkg::DD_W;
    localparam int PR_W   = svd_pkg::PR_W;
    localparam int DW     = svd_pkg::DENS_W;
    localparam int OUT_DATA_FILL = svd_pkg::OUT_DATA_W - DW - 1;

    localparam logic signed [PR_W-1:0] DMAX = PR_W'(svd_pkg::DENS_FULL);
    localparam logic signed [PR_W-1:0] DMIN = -PR_W'(svd_pkg::DENS_FULL + 1);
    localparam logic signed [PR_W-1:0] BIAS = PR_W'((1 << svd_pkg::FRAC_BITS) - 1);

    // Configuration registers.
    logic signed [CW-1:0]                    cx_reg, cy_reg, cz_reg;
    logic [svd_pkg::RADIUS_WIDTH-1:0]        radius_reg;
    logic [svd_pkg::VOXEL_WIDTH-1:0]         voxel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            radius_reg <= svd_pkg::RADIUS_RST;
            voxel_reg  <= svd_pkg::VOXEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                svd_pkg::CFG_CENTER_X: cx_reg     <= cfg_data[CW-1:0];
                svd_pkg::CFG_CENTER_Y: cy_reg     <= cfg_data[CW-1:0];
                svd_pkg::CFG_CENTER_Z: cz_reg     <= cfg_data[CW-1:0];
                svd_pkg::CFG_RADIUS:   radius_reg <= cfg_data[svd_pkg::RADIUS_WIDTH-1:0];
                svd_pkg::CFG_VOXEL:    voxel_reg  <= cfg_data[svd_pkg::VOXEL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Derived thresholds, refreshed every cycle from the configuration.
    logic [OUT_W-1:0] outer_reg, inner_abs_reg;
    logic [SQ_W-1:0]  outer_sq_reg, inner_sq_reg;

    always_ff @(posedge clk)
    begin
        outer_reg     <= OUT_W'(radius_reg) + OUT_W'(voxel_reg);
        inner_abs_reg <= (OUT_W'(radius_reg) >= OUT_W'(voxel_reg))
                         ? OUT_W'(radius_reg) - OUT_W'(voxel_reg)
                         : OUT_W'(voxel_reg) - OUT_W'(radius_reg);
        outer_sq_reg  <= SQ_W'(outer_reg) * SQ_W'(outer_reg);
        inner_sq_reg  <= SQ_W'(inner_abs_reg) * SQ_W'(inner_abs_reg);
    end

    // Valid bits and per-stage enables. A stage moves when it is empty or the next one moves.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vp1_reg, vp2_reg, out_v_reg;
    logic en1, en2, en3, en4, en5, en6, enp1, enp2, en_out;
    logic [RT_W:0] vq_reg;
    logic [RT_W:0] enq;

    assign en_out = !out_v_reg || m_axis_tready;
    assign enp2   = !vp2_reg || en_out;
    assign enp1   = !vp1_reg || enp2;
    assign enq[RT_W] = !vq_reg[RT_W] || enp1;

    genvar g;
    generate
        for (g = 0; g < RT_W; g++)
        begin : g_en
            assign enq[g] = !vq_reg[g] || enq[g+1];
        end
    endgenerate

    assign en6 = enq[0];
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            vq_reg    <= '0;
            vp1_reg   <= 1'b0;
            vp2_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_axis_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
            if (en6)
                vq_reg[0] <= v5_reg;
            for (int j = 1; j <= RT_W; j++)
            begin
                if (enq[j])
                    vq_reg[j] <= vq_reg[j-1];
            end
            if (enp1)
                vp1_reg <= vq_reg[RT_W];
            if (enp2)
                vp2_reg <= vp1_reg;
            if (en_out)
                out_v_reg <= vp2_reg;
        end
    end

    // Stage 1: signed differences to the centre.
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [CW-1:0]     pos_x, pos_y, pos_z;

    assign pos_x = s_axis_tdata[CW-1:0];
    assign pos_y = s_axis_tdata[2*CW-1:CW];
    assign pos_z = s_axis_tdata[3*CW-1:2*CW];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            dx_reg <= DIFF_W'(pos_x) - DIFF_W'(cx_reg);
            dy_reg <= DIFF_W'(pos_y) - DIFF_W'(cy_reg);
            dz_reg <= DIFF_W'(pos_z) - DIFF_W'(cz_reg);
        end
    end

    // Stage 2: magnitudes.
    logic [DIFF_W-1:0] mx_reg, my_reg, mz_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            mx_reg <= dx_reg[DIFF_W-1] ? unsigned'(-dx_reg) : unsigned'(dx_reg);
            my_reg <= dy_reg[DIFF_W-1] ? unsigned'(-dy_reg) : unsigned'(dy_reg);
            mz_reg <= dz_reg[DIFF_W-1] ? unsigned'(-dz_reg) : unsigned'(dz_reg);
        end
    end

    // Stage 3: early far test; an in-range magnitude fits below the outer bound.
    logic [CMP_W-1:0] mx_ext, my_ext, mz_ext, outer_ext;
    logic [OUT_W-1:0] ax_reg, ay_reg, az_reg;
    logic             far3_reg;

    assign mx_ext    = CMP_W'(mx_reg);
    assign my_ext    = CMP_W'(my_reg);
    assign mz_ext    = CMP_W'(mz_reg);
    assign outer_ext = CMP_W'(outer_reg);

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            far3_reg <= (mx_ext >= outer_ext) || (my_ext >= outer_ext)
                        || (mz_ext >= outer_ext);
            ax_reg   <= mx_ext[OUT_W-1:0];
            ay_reg   <= my_ext[OUT_W-1:0];
            az_reg   <= mz_ext[OUT_W-1:0];
        end
    end

    // Stage 4: one square per axis.
    logic [SQ_W-1:0] sx_reg, sy_reg, sz_reg;
    logic            far4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            sx_reg   <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sy_reg   <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
            sz_reg   <= SQ_W'(az_reg) * SQ_W'(az_reg);
            far4_reg <= far3_reg;
        end
    end

    // Stage 5: squared distance; three terms cannot overflow the sum width.
    logic [SUM_W-1:0] dist_reg;
    logic             far5_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            dist_reg <= SUM_W'(sx_reg) + SUM_W'(sy_reg) + SUM_W'(sz_reg);
            far5_reg <= far4_reg;
        end
    end

    // Stage 6 feeds the root pipeline: classify the voxel and seed the remainder.
    logic [SQ_W-1:0] rem_reg   [0:RT_W];
    logic [RT_W-1:0] root_reg  [0:RT_W];
    logic            touch_reg [0:RT_W];
    logic            full_reg  [0:RT_W];
    logic            touch_next;

    assign touch_next = !far5_reg && (dist_reg < SUM_W'(outer_sq_reg));

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            touch_reg[0] <= touch_next;
            full_reg[0]  <= touch_next && (dist_reg < SUM_W'(inner_sq_reg));
            rem_reg[0]   <= dist_reg[SQ_W-1:0];
            root_reg[0]  <= '0;
        end
    end

    // Square root, one result bit per stage from the top down.
    generate
        for (g = 0; g < RT_W; g++)
        begin : g_root
            localparam int BIT = RT_W - 1 - g;
            logic [TR_W-1:0] trial;
            logic            take;

            assign trial = (TR_W'(root_reg[g]) << (BIT + 1)) + (TR_W'(1) << (2 * BIT));
            assign take  = TR_W'(rem_reg[g]) >= trial;

            always_ff @(posedge clk)
            begin
                if (enq[g+1])
                begin
                    rem_reg[g+1]   <= take ? rem_reg[g] - trial[SQ_W-1:0] : rem_reg[g];
                    root_reg[g+1]  <= take ? (root_reg[g] | (RT_W'(1) << BIT)) : root_reg[g];
                    touch_reg[g+1] <= touch_reg[g];
                    full_reg[g+1]  <= full_reg[g];
                end
            end
        end
    endgenerate

    // Ramp stage 1: radius minus root, signed.
    logic signed [DD_W-1:0] ramp_reg;
    logic                   touch_p1_reg, full_p1_reg;

    always_ff @(posedge clk)
    begin
        if (enp1)
        begin
            ramp_reg     <= signed'(DD_W'(radius_reg)) - signed'(DD_W'(root_reg[RT_W]));
            touch_p1_reg <= touch_reg[RT_W];
            full_p1_reg  <= full_reg[RT_W];
        end
    end

    // Ramp stage 2: times 127 as a shift and subtract.
    logic signed [PR_W-1:0] prod_reg;
    logic                   touch_p2_reg, full_p2_reg;

    always_ff @(posedge clk)
    begin
        if (enp2)
        begin
            prod_reg     <= (PR_W'(ramp_reg) <<< 7) - PR_W'(ramp_reg);
            touch_p2_reg <= touch_p1_reg;
            full_p2_reg  <= full_p1_reg;
        end
    end

    // Output stage: scale toward zero, saturate and pick the density.
    logic signed [PR_W-1:0] biased;
    logic signed [PR_W-1:0] scaled;
    logic signed [DW-1:0]   density_next;
    logic signed [DW-1:0]   density_reg;
    logic                   touched_reg;

    always_comb
    begin
        biased = prod_reg + (prod_reg[PR_W-1] ? BIAS : '0);
        scaled = biased >>> svd_pkg::FRAC_BITS;
        if (!touch_p2_reg)
            density_next = '0;
        else if (full_p2_reg || scaled > DMAX)
            density_next = DW'(svd_pkg::DENS_FULL);
        else if (scaled < DMIN)
            density_next = DMIN[DW-1:0];
        else
            density_next = scaled[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            density_reg <= density_next;
            touched_reg <= touch_p2_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {(OUT_DATA_FILL)'(0), density_reg, touched_reg};

    // An untouched voxel always carries zero density.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[DW:1] == '0))
        else $error("untouched voxel with non-zero density");

    // The final remainder of the root stays within 2*root, so the root is the floor.
    assert property (@(posedge clk) disable iff (!rst_n)
        vq_reg[RT_W] |-> (rem_reg[RT_W] <= (SQ_W'(root_reg[RT_W]) << 1)))
        else $error("square root remainder out of range");

    // An empty output register never blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_v_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // A fully inside voxel is always touched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (vp2_reg && full_p2_reg) |-> touch_p2_reg)
        else $error("inside voxel not marked touched");

endmodule
